>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Non-overlapping implication: the consequent is checked after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> sv/cke_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cke_pkg;
    localparam int MaxDigits = 9;
    localparam int ValW = 30;
    localparam int CntW = 4;
    localparam int CountLimit = 15;
    localparam logic [ValW-1:0] ValueLimit = 30'd999999999;

    localparam logic [2:0] CMD_DIGIT = 3'd0;
    localparam logic [2:0] CMD_ADD = 3'd1;
    localparam logic [2:0] CMD_SUB = 3'd2;
    localparam logic [2:0] CMD_MUL = 3'd3;
    localparam logic [2:0] CMD_DIV = 3'd4;
    localparam logic [2:0] CMD_EQUALS = 3'd5;
    localparam logic [2:0] CMD_CLEAR = 3'd6;

    localparam logic [2:0] ST_ENTRY = 3'd0;
    localparam logic [2:0] ST_RESULT = 3'd1;
    localparam logic [2:0] ST_TOO_BIG = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;
    localparam logic [2:0] ST_UNCHANGED = 3'd6;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] digit;
    } key_t;

    typedef struct packed {
        logic [ValW-1:0] shown_value;
        logic [CntW-1:0] shown_digits;
        logic [2:0] status;
    } disp_t;

    // Request to and answer from the serial arithmetic unit.
    typedef struct packed {
        logic start;
        logic [2:0] op;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic [2:0] status;
        logic [ValW-1:0] value;
    } alu_rsp_t;
endpackage
`default_nettype wire

>>> sv/cke_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cke_key_if;
    logic valid;
    logic ready;
    cke_pkg::key_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cke_disp_if;
    logic valid;
    logic ready;
    cke_pkg::disp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/cke_alu.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Bit-serial arithmetic: one bit of the operands per cycle.
module cke_alu (
    input wire logic clk,
    input wire logic rst_n,
    input wire cke_pkg::alu_req_t req,
    output cke_pkg::alu_rsp_t rsp
);
    localparam int W = cke_pkg::ValW;
    localparam int CW = $clog2(W + 1);

    logic busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0] op_reg, op_next;
    logic [W-1:0] a_reg, a_next;   // shifts out (add/sub lsb first, div msb first; held for mul)
    logic [W-1:0] b_reg, b_next;
    logic [W:0] acc_reg, acc_next; // product or remainder
    logic [W-1:0] q_reg, q_next;   // quotient, sum or difference bits
    logic carry_reg, carry_next;
    logic big_reg, big_next;       // product has overflowed the limit
    logic done_reg, done_next;
    logic [2:0] st_reg, st_next;
    logic [W-1:0] val_reg, val_next;

    logic [W:0] sum;
    logic [W:0] trial;
    logic fa;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        q_next = q_reg;
        carry_next = carry_reg;
        big_next = big_reg;
        done_next = 1'b0;
        sum = '0;
        trial = '0;
        fa = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            op_next = req.op;
            a_next = req.a;
            b_next = req.b;
            acc_next = '0;
            q_next = '0;
            carry_next = (req.op == cke_pkg::CMD_SUB);
            big_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            case (op_reg)
                cke_pkg::CMD_ADD, cke_pkg::CMD_SUB:
                begin
                    // One full adder step per cycle; subtract adds the inverse.
                    fa = a_reg[0] ^ (b_reg[0] ^ (op_reg == cke_pkg::CMD_SUB)) ^ carry_reg;
                    carry_next = (a_reg[0] & (b_reg[0] ^ (op_reg == cke_pkg::CMD_SUB)))
                        | (carry_reg & (a_reg[0] ^ b_reg[0] ^ (op_reg == cke_pkg::CMD_SUB)));
                    q_next = {fa, q_reg[W-1:1]};
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
                cke_pkg::CMD_MUL:
                begin
                    // Shift-add from the top bit of b: acc = acc*2, plus a when that bit is 1.
                    sum = {acc_reg[W-1:0], 1'b0};
                    if (acc_reg[W] || acc_reg[W-1])
                        big_next = 1'b1;
                    if (b_reg[W-1])
                        sum = sum + {1'b0, a_reg};
                    if (sum > {1'b0, cke_pkg::ValueLimit})
                        big_next = 1'b1;
                    acc_next = sum;
                    b_next = b_reg << 1;
                end
                default:
                begin
                    // Restoring division, one quotient bit per cycle.
                    trial = {acc_reg[W-1:0], a_reg[W-1]};
                    a_next = a_reg << 1;
                    if (trial >= {1'b0, b_reg})
                    begin
                        acc_next = trial - {1'b0, b_reg};
                        q_next = {q_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = trial;
                        q_next = {q_reg[W-2:0], 1'b0};
                    end
                end
            endcase
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg == 1'b0 && cnt_reg == CW'(W))
        begin
            cnt_next = '0;
        end
    end

    // Final verdict, registered while done_reg is high and shown with rsp.done.
    logic fin_reg;
    always_comb
    begin
        st_next = cke_pkg::ST_RESULT;
        val_next = '0;
        case (op_reg)
            cke_pkg::CMD_ADD:
                if ({carry_reg, q_reg} > {1'b0, cke_pkg::ValueLimit})
                    st_next = cke_pkg::ST_TOO_BIG;
                else
                    val_next = q_reg;
            cke_pkg::CMD_SUB:
                if (!carry_reg)
                    st_next = cke_pkg::ST_TOO_SMALL;
                else
                    val_next = q_reg;
            cke_pkg::CMD_MUL:
                if (big_reg)
                    st_next = cke_pkg::ST_TOO_BIG;
                else
                    val_next = acc_reg[W-1:0];
            default:
                if (b_reg == '0)
                    st_next = cke_pkg::ST_DIV_ZERO;
                else
                    val_next = q_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
            fin_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
            fin_reg <= done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg <= a_next;
        b_reg <= (busy_reg && op_reg == cke_pkg::CMD_MUL && !req.start) ? b_next
                 : (req.start ? req.b : (busy_reg && op_reg != cke_pkg::CMD_DIV
                    && op_reg != cke_pkg::CMD_MUL ? b_next : b_reg));
        acc_reg <= acc_next;
        q_reg <= q_next;
        carry_reg <= carry_next;
        big_reg <= big_next;
        if (done_reg)
        begin
            st_reg <= st_next;
            val_reg <= val_next;
        end
    end

    assign rsp.done = fin_reg;
    assign rsp.status = st_reg;
    assign rsp.value = val_reg;

    `ASSERT_IMPL(a_no_start_busy, clk, rst_n, busy_reg, !req.start)
    `ASSERT_NEXT(a_fin_follows, clk, rst_n, done_reg, fin_reg && !busy_reg)
endmodule
`default_nettype wire

>>> sv/cke_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Key decoder and calculator state; drives the arithmetic unit.
module cke_ctrl (
    input wire logic clk,
    input wire logic rst_n,
    cke_key_if.sink key,
    cke_disp_if.source disp,
    output cke_pkg::alu_req_t req,
    input wire cke_pkg::alu_rsp_t rsp
);
    localparam int W = cke_pkg::ValW;
    localparam int N = cke_pkg::CntW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL = 4'b0010,
        S_EVAL = 4'b0100,
        S_OUT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [W-1:0] ev_reg, ev_next;
    logic [N-1:0] ec_reg, ec_next;
    logic [W-1:0] op0_reg, op0_next, op1_reg, op1_next;
    logic [1:0] oc_reg, oc_next;
    logic [2:0] pend_reg, pend_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [3:0] dig_reg, dig_next;
    logic [W+3:0] nv_reg, nv_next;      // entry times ten plus digit
    logic ovalid_reg, ovalid_next;
    cke_pkg::disp_t od_reg, od_next;
    logic start;

    // Entry value times ten, registered before the compare.
    logic [W+3:0] times_ten;
    assign times_ten = {1'b0, ev_reg, 3'b000} + {3'b000, ev_reg, 1'b0}
        + {{W{1'b0}}, dig_reg};

    assign key.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign disp.valid = ovalid_reg;
    assign disp.data = od_reg;

    always_comb
    begin
        logic [1:0] oc;
        logic [W-1:0] o0;
        logic [W-1:0] o1;
        state_next = state_reg;
        ev_next = ev_reg;
        ec_next = ec_reg;
        op0_next = op0_reg;
        op1_next = op1_reg;
        oc_next = oc_reg;
        pend_next = pend_reg;
        cmd_next = cmd_reg;
        dig_next = dig_reg;
        nv_next = nv_reg;
        ovalid_next = ovalid_reg;
        od_next = od_reg;
        start = 1'b0;
        oc = oc_reg;
        o0 = op0_reg;
        o1 = op1_reg;
        if (disp.valid && disp.ready)
            ovalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (key.valid && key.ready)
                begin
                    cmd_next = key.data.command;
                    dig_next = key.data.digit;
                    od_next.shown_value = ev_reg;
                    od_next.shown_digits = ec_reg;
                    od_next.status = cke_pkg::ST_UNCHANGED;
                    case (key.data.command)
                        cke_pkg::CMD_DIGIT:
                            state_next = S_MUL;
                        cke_pkg::CMD_ADD, cke_pkg::CMD_SUB, cke_pkg::CMD_MUL,
                        cke_pkg::CMD_DIV, cke_pkg::CMD_EQUALS:
                        begin
                            if (key.data.command != cke_pkg::CMD_EQUALS || pend_reg != '0)
                            begin
                                // Push a non-empty entry.
                                if (ec_reg != '0 && oc_reg == 2'd0)
                                begin
                                    o0 = ev_reg;
                                    oc = 2'd1;
                                end
                                else if (ec_reg != '0 && oc_reg == 2'd1)
                                begin
                                    o1 = ev_reg;
                                    oc = 2'd2;
                                end
                                op0_next = o0;
                                op1_next = o1;
                                oc_next = oc;
                                if (oc == 2'd2 && pend_reg != '0)
                                begin
                                    start = 1'b1;
                                    state_next = S_EVAL;
                                end
                                else
                                begin
                                    if (key.data.command == cke_pkg::CMD_EQUALS)
                                        oc_next = 2'd0;
                                    else
                                    begin
                                        pend_next = key.data.command;
                                        ev_next = '0;
                                        ec_next = '0;
                                        od_next.shown_value = '0;
                                        od_next.shown_digits = '0;
                                    end
                                    ovalid_next = 1'b1;
                                end
                            end
                            else
                                ovalid_next = 1'b1;
                        end
                        cke_pkg::CMD_CLEAR:
                        begin
                            ev_next = '0;
                            ec_next = '0;
                            od_next.shown_value = '0;
                            od_next.shown_digits = '0;
                            od_next.status = cke_pkg::ST_CLEARED;
                            ovalid_next = 1'b1;
                        end
                        default:
                            ovalid_next = 1'b1;
                    endcase
                end
            S_MUL:
            begin
                nv_next = times_ten;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (dig_reg <= 4'd9 && 32'(ec_reg) < cke_pkg::MaxDigits
                    && 32'(ec_reg) < cke_pkg::CountLimit
                    && nv_reg <= (W+4)'(cke_pkg::ValueLimit))
                begin
                    ev_next = nv_reg[W-1:0];
                    ec_next = ec_reg + 1'b1;
                    od_next.shown_value = nv_reg[W-1:0];
                    od_next.shown_digits = ec_reg + 1'b1;
                    od_next.status = cke_pkg::ST_ENTRY;
                end
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_EVAL:
                if (rsp.done)
                begin
                    ev_next = '0;
                    ec_next = '0;
                    od_next.shown_value = rsp.value;
                    od_next.shown_digits = '0;
                    od_next.status = rsp.status;
                    if (rsp.status == cke_pkg::ST_RESULT)
                    begin
                        op0_next = rsp.value;
                        oc_next = 2'd1;
                    end
                    else
                        oc_next = 2'd0;
                    if (cmd_reg == cke_pkg::CMD_EQUALS)
                        oc_next = 2'd0;
                    else
                        pend_next = cmd_reg;
                    ovalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign req.start = start;
    assign req.op = pend_reg;
    assign req.a = op0_next;
    assign req.b = op1_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ev_reg <= '0;
            ec_reg <= '0;
            op0_reg <= '0;
            op1_reg <= '0;
            oc_reg <= '0;
            pend_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ev_reg <= ev_next;
            ec_reg <= ec_next;
            op0_reg <= op0_next;
            op1_reg <= op1_next;
            oc_reg <= oc_next;
            pend_reg <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        dig_reg <= dig_next;
        nv_reg <= nv_next;
        od_reg <= od_next;
    end

    `ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, !key.ready)
    `ASSERT_IMPL(a_start_has_two, clk, rst_n, start, oc_next == 2'd2)
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, disp.valid && !disp.ready, disp.valid)
endmodule
`default_nettype wire

>>> sv/calculator_keystroke_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Four-function calculator keystroke engine.
// Channel key carries one keystroke (command, digit) per transaction;
// channel disp returns exactly one display transaction per key
// (shown_value, shown_digits, status).
// A digit key passes through S_MUL and S_OUT before its display
// transaction; clear, equals without evaluation and lone operators
// answer straight from S_IDLE, and an evaluating operator or equals
// waits in S_EVAL on the bit-serial unit, one operand bit per cycle.
// One key is processed at a time; key.ready is low while a key is being
// worked on or while its display transaction is still waiting.
// If the receiver stalls, the display transaction is held stable and no
// new key is taken until it is delivered.
// Reset (rst_n low) empties the entry, drops both operands and clears
// the pending operator.
module calculator_keystroke_engine (
    input wire logic clk,
    input wire logic rst_n,
    cke_key_if.sink key,
    cke_disp_if.source disp
);
    cke_pkg::alu_req_t req;
    cke_pkg::alu_rsp_t rsp;

    cke_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .key(key),
        .disp(disp),
        .req(req),
        .rsp(rsp)
    );

    cke_alu u_alu (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );
endmodule
`default_nettype wire

>>> sim/calculator_keystroke_engine_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module calculator_keystroke_engine_tb;
    import cke_pkg::*;

    localparam int NUM_RANDOM = 600;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    cke_key_if key_ch ();
    cke_disp_if disp_ch ();

    calculator_keystroke_engine u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .key(key_ch.sink),
        .disp(disp_ch.source)
    );

    // Calculator state mirrored by the predictor.
    logic [ValW-1:0] calc_entry;
    logic [CntW-1:0] calc_count;
    logic [ValW-1:0] calc_opnd [2];
    logic [1:0] calc_nopnd;
    logic [2:0] calc_pending;

    disp_t display_queue [$];
    int mismatches;
    int keys_sent;
    int displays_seen;
    int cycle_count;
    bit stimulus_done;
    bit long_hold;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d (display %0d)", what, got, want,
                 displays_seen);
        mismatches++;
    endtask

    task automatic calc_reset();
        calc_entry = '0;
        calc_count = '0;
        calc_opnd[0] = '0;
        calc_opnd[1] = '0;
        calc_nopnd = '0;
        calc_pending = '0;
    endtask

    // Pushes a non-empty entry onto the operand store while there is room.
    function automatic void calc_push();
        if (calc_count != 0 && calc_nopnd < 2)
        begin
            calc_opnd[calc_nopnd[0]] = calc_entry;
            calc_nopnd++;
        end
    endfunction

    // Applies the pending operation to both operands, if there are two, and returns the status and value.
    function automatic void calc_evaluate(output logic [2:0] st,
                                          output logic [ValW-1:0] val);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        st = ST_RESULT;
        r = '0;
        val = '0;
        if (calc_nopnd < 2 || calc_pending < CMD_ADD || calc_pending > CMD_DIV)
        begin
            st = ST_UNCHANGED;
            return;
        end
        a = calc_opnd[0];
        b = calc_opnd[1];
        case (calc_pending)
            CMD_ADD:
            begin
                r = a + b;
                if (r > ValueLimit)
                    st = ST_TOO_BIG;
            end
            CMD_SUB:
            begin
                if (b > a)
                    st = ST_TOO_SMALL;
                else
                    r = a - b;
            end
            CMD_MUL:
            begin
                r = a * b;
                if (r > ValueLimit)
                    st = ST_TOO_BIG;
            end
            default:
            begin
                if (b == 0)
                    st = ST_DIV_ZERO;
                else
                    r = a / b;
            end
        endcase
        calc_entry = '0;
        calc_count = '0;
        if (st != ST_RESULT)
        begin
            calc_nopnd = '0;
            return;
        end
        calc_opnd[0] = r[ValW-1:0];
        calc_nopnd = 2'd1;
        val = r[ValW-1:0];
    endfunction

    // Works out the display that one keystroke produces.
    function automatic disp_t calc_display(input key_t k);
        disp_t d;
        logic [2:0] st;
        logic [ValW-1:0] val;
        logic [63:0] nv;
        bit show_entry;
        st = ST_UNCHANGED;
        val = '0;
        show_entry = 1'b1;
        case (k.command)
            CMD_DIGIT:
            begin
                nv = 64'(calc_entry) * 10 + k.digit;
                if (k.digit <= 9 && calc_count < MaxDigits && calc_count < CountLimit
                    && nv <= ValueLimit)
                begin
                    calc_entry = nv[ValW-1:0];
                    calc_count++;
                    st = ST_ENTRY;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                calc_push();
                calc_evaluate(st, val);
                calc_pending = k.command;
                calc_entry = '0;
                calc_count = '0;
                if (st != ST_UNCHANGED)
                    show_entry = 1'b0;
            end
            CMD_EQUALS:
            begin
                if (calc_pending != 0)
                begin
                    calc_push();
                    calc_evaluate(st, val);
                    calc_nopnd = '0;
                    if (st != ST_UNCHANGED)
                        show_entry = 1'b0;
                end
            end
            CMD_CLEAR:
            begin
                calc_entry = '0;
                calc_count = '0;
                st = ST_CLEARED;
                show_entry = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (show_entry)
        begin
            d.shown_value = calc_entry;
            d.shown_digits = calc_count;
        end
        else
        begin
            d.shown_value = val;
            d.shown_digits = '0;
        end
        d.status = st;
        return d;
    endfunction

    // Directed table: key and, where obvious, the display it must give.
    typedef struct {
        key_t k;
        bit typed;
        disp_t want;
    } key_row_t;

    key_row_t directed [$];

    function automatic key_row_t row(input logic [2:0] cmd, input logic [3:0] dig,
                                     input bit typed = 0, input logic [ValW-1:0] v = 0,
                                     input logic [3:0] n = 0, input logic [2:0] st = 0);
        key_row_t r;
        r.k.command = cmd;
        r.k.digit = dig;
        r.typed = typed;
        r.want.shown_value = v;
        r.want.shown_digits = n;
        r.want.status = st;
        return r;
    endfunction

    task automatic build_directed();
        // Equals straight after reset, then a lone clear.
        directed.push_back(row(CMD_EQUALS, 0, 1, 0, 0, ST_UNCHANGED));
        directed.push_back(row(CMD_CLEAR, 0, 1, 0, 0, ST_CLEARED));
        // Nine nines fill the entry; a tenth digit is ignored.
        for (int i = 0; i < 9; i++)
            directed.push_back(row(CMD_DIGIT, 9));
        directed.push_back(row(CMD_DIGIT, 9, 1, 999999999, 9, ST_UNCHANGED));
        // Adding one to the largest value overflows.
        directed.push_back(row(CMD_ADD, 0));
        directed.push_back(row(CMD_DIGIT, 1));
        directed.push_back(row(CMD_EQUALS, 0, 1, 0, 0, ST_TOO_BIG));
        // Digit value out of range, then divide by zero.
        directed.push_back(row(CMD_DIGIT, 4'd15, 1, 0, 0, ST_UNCHANGED));
        directed.push_back(row(CMD_DIGIT, 7));
        directed.push_back(row(CMD_DIV, 0));
        directed.push_back(row(CMD_DIGIT, 0));
        directed.push_back(row(CMD_EQUALS, 0, 1, 0, 0, ST_DIV_ZERO));
        // Negative difference, then a multiply and the unknown command.
        directed.push_back(row(CMD_DIGIT, 3));
        directed.push_back(row(CMD_SUB, 0));
        directed.push_back(row(CMD_DIGIT, 5));
        directed.push_back(row(CMD_MUL, 0, 1, 0, 0, ST_TOO_SMALL));
        directed.push_back(row(3'd7, 4'd8));
        directed.push_back(row(CMD_CLEAR, 0, 1, 0, 0, ST_CLEARED));
    endtask

    // Random key, mostly digits and operators forming sensible sums.
    function automatic key_t random_key();
        key_t k;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            k.command = CMD_DIGIT;
            k.digit = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                   : 4'($urandom_range(0, 9));
        end
        else
        begin
            if (pick < 85)
                k.command = 3'($urandom_range(CMD_ADD, CMD_DIV));
            else if (pick < 94)
                k.command = CMD_EQUALS;
            else if (pick < 98)
                k.command = CMD_CLEAR;
            else
                k.command = 3'd7;
            k.digit = 4'($urandom_range(0, 15));
        end
        return k;
    endfunction

    // Idles the sender for a random number of cycles; a zero gap keeps valid high.
    task automatic random_gap(input int long_max);
        int n;
        if ($urandom_range(0, 2) == 0)
            n = 0;
        else if ($urandom_range(0, 19) == 0)
            n = $urandom_range(5, long_max);
        else
            n = $urandom_range(1, 3);
        if (n > 0)
            key_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Offers one keystroke and holds it until accepted.
    task automatic send_key(input key_t k);
        key_ch.data <= k;
        key_ch.valid <= 1'b1;
        @(posedge clk);
        while (!key_ch.ready)
            @(posedge clk);
        display_queue.push_back(calc_display(k));
        keys_sent++;
        @(negedge clk);
    endtask

    // Sender.
    initial
    begin
        key_row_t r;
        disp_t d;
        key_ch.valid = 1'b0;
        key_ch.data = '0;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        mismatches = 0;
        keys_sent = 0;
        calc_reset();
        build_directed();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // Directed rows: typed rows are also checked against the table.
        foreach (directed[i])
        begin
            r = directed[i];
            send_key(r.k);
            if (r.typed)
            begin
                d = display_queue[$];
                if (d != r.want)
                    report_mismatch("directed table", i, -1);
            end
            random_gap(12);
        end
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            send_key(random_key());
            random_gap(30);
        end
        key_ch.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off to back up the input.
    initial
    begin
        long_hold = 1'b0;
        disp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold && keys_sent > 40)
            begin
                long_hold = 1'b1;
                disp_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                disp_ch.ready <= 1'b0;
                if ($urandom_range(0, 19) == 0)
                    repeat ($urandom_range(5, 40)) @(negedge clk);
            end
            else
            begin
                disp_ch.ready <= 1'b1;
            end
        end
    end

    // Display checker.
    always @(posedge clk)
    begin
        disp_t want;
        if (rst_n && disp_ch.valid && disp_ch.ready)
        begin
            displays_seen++;
            if (display_queue.size() == 0)
            begin
                report_mismatch("unexpected display", displays_seen, 0);
            end
            else
            begin
                want = display_queue.pop_front();
                if (disp_ch.data.shown_value !== want.shown_value)
                    report_mismatch("shown_value", disp_ch.data.shown_value,
                                    want.shown_value);
                if (disp_ch.data.shown_digits !== want.shown_digits)
                    report_mismatch("shown_digits", disp_ch.data.shown_digits,
                                    want.shown_digits);
                if (disp_ch.data.status !== want.status)
                    report_mismatch("status", disp_ch.data.status, want.status);
            end
        end
    end

    // Watchdog.
    initial
    begin
        displays_seen = 0;
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // End of run.
    initial
    begin
        wait (stimulus_done);
        while (display_queue.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d keystrokes (directed and random), checked %0d displays.",
                 keys_sent, displays_seen);
        $display("Covered digits, all operators, overflow, underflow and divide by zero.");
        if (mismatches == 0 && display_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+sv
sv/cke_pkg.sv
sv/cke_if.sv
sv/cke_alu.sv
sv/cke_ctrl.sv
sv/calculator_keystroke_engine.sv
sim/calculator_keystroke_engine_tb.sv
